// File: src/announce_reply_parser_unit_assert.svh
// Assertion macros for the announce reply parser, removable with NO_ASSERTIONS.
`ifndef ANNOUNCE_REPLY_PARSER_UNIT_ASSERT_SVH
`define ANNOUNCE_REPLY_PARSER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define ARP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("announce reply parser: same-cycle check failed");

`define ARP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("announce reply parser: next-cycle check failed");

`else

`define ARP_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define ARP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: src/arp_pkg.sv
// Types and constants shared by the announce reply parser files.
`default_nettype none

package arp_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic        has_peer;
      logic [31:0] peer_ip;
      logic [15:0] peer_port;
      logic        final_res;
      logic [1:0]  status;
      logic [16:0] interval_s;
      logic [31:0] leechers;
      logic [31:0] seeders;
   } rsp_payload_type;

   localparam int MAX_DATAGRAM_BYTES = 65536;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_IGNORED = 2'd1;
   localparam logic [1:0] STATUS_ERROR   = 2'd2;

   localparam logic [31:0] ACTION_ANNOUNCE = 32'd1;
   localparam logic [31:0] ACTION_ERROR    = 32'd3;

   // Offsets of the last byte of each header word.
   localparam logic [4:0] ACTION_END   = 5'd3;
   localparam logic [4:0] TXN_END      = 5'd7;
   localparam logic [4:0] INTERVAL_END = 5'd11;
   localparam logic [4:0] LEECHER_END  = 5'd15;
   localparam logic [4:0] SEEDER_END   = 5'd19;

   localparam logic [15:0] TXN_BYTES    = 16'd8;
   localparam logic [15:0] HEADER_BYTES = 16'd20;
   localparam logic [15:0] POS_SAT      = 16'hFFFF;
   localparam logic [2:0]  RECORD_LAST  = 3'd5;

   localparam logic [31:0] INTERVAL_DEFAULT = 32'd1800;
   localparam logic [31:0] INTERVAL_MIN     = 32'd300;
   localparam logic [31:0] INTERVAL_MAX     = 32'd86400;

endpackage

`default_nettype wire

// File: src/arp_chan_if.sv
// Valid/ready channel interface with a typed payload.
`default_nettype none

interface arp_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: src/announce_reply_parser_unit.sv
// Announce reply parser: streams a tracker reply datagram and emits peers and a final status.
//
// Usage:
//   req_chan carries one datagram byte per transaction, network order, with
//   last_byte set on the final byte. csr_chan writes the expected transaction
//   id; it is always ready and should be written between datagrams.
//   rsp_chan gives at most one result per byte: a peer record when a record
//   with a nonzero port completes in a matching announce reply, a final
//   result with status, normalized interval and counters on the last byte, or both.
// Path: an accepted byte is captured in the input register; its result is
// then captured in the result register, which drives rsp_chan.
// Throughput: one byte per cycle unless a result stalls; the parse state is
// updated by one pass of shift, compare and increment logic from the input register.
// Stalls: while rsp_chan.ready is low, bytes that cause no result still
// advance; a byte that causes a result waits in the input register while the
// result register is full, and req_chan.ready drops while it is held there.
// Reset: clears the channel valids, the parse state and the expected
// transaction id to zero. After each last byte the parse state returns to
// its reset value.
`default_nettype none
`include "announce_reply_parser_unit_assert.svh"

module announce_reply_parser_unit #(
   parameter int MAX_BYTES = arp_pkg::MAX_DATAGRAM_BYTES
) (
   input  wire logic  clock,
   input  wire logic  reset,
   arp_chan_if.sink   req_chan,
   arp_chan_if.source rsp_chan,
   arp_chan_if.sink   csr_chan
);
   import arp_pkg::*;

   localparam logic [16:0] MAX_POS = 17'(MAX_BYTES);

   // Input register.
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;

   // Parse state.
   logic [15:0] pos_ff, pos_in;
   logic [31:0] word_ff, word_in;
   logic        announce_ff, announce_in;
   logic        error_ff, error_in;
   logic        matched_ff, matched_in;
   logic [31:0] interval_ff, interval_in;
   logic [31:0] leech_ff, leech_in;
   logic [31:0] seed_ff, seed_in;
   logic [47:0] record_ff, record_in;
   logic [2:0]  rec_pos_ff, rec_pos_in;
   logic [31:0] txn_ff;

   // Result register.
   logic            out_valid_ff;
   rsp_payload_type out_ff;
   rsp_payload_type result;

   logic        parse_en;
   logic        peer_found;
   logic        result_present;
   logic        out_free;
   logic        advance;
   logic        req_take;
   logic [31:0] iv_raw;
   logic [16:0] iv_norm;
   logic [1:0]  status_w;

   always_comb begin
      word_in     = word_ff;
      announce_in = announce_ff;
      error_in    = error_ff;
      matched_in  = matched_ff;
      interval_in = interval_ff;
      leech_in    = leech_ff;
      seed_in     = seed_ff;
      record_in   = record_ff;
      rec_pos_in  = rec_pos_ff;
      peer_found  = 1'b0;

      parse_en = (pos_ff != POS_SAT) && ({1'b0, pos_ff} < MAX_POS);

      if (parse_en) begin
         if (pos_ff < HEADER_BYTES) begin
            word_in = {word_ff[23:0], in_byte_ff};
            unique case (pos_ff[4:0])
               ACTION_END: begin
                  announce_in = (word_in == ACTION_ANNOUNCE);
                  error_in    = (word_in == ACTION_ERROR);
               end
               TXN_END:      matched_in  = (word_in == txn_ff);
               INTERVAL_END: interval_in = word_in;
               LEECHER_END:  leech_in    = word_in;
               SEEDER_END:   seed_in     = word_in;
               default:      ;
            endcase
         end else begin
            record_in = {record_ff[39:0], in_byte_ff};
            if (rec_pos_ff == RECORD_LAST) begin
               rec_pos_in = 3'd0;
               peer_found = announce_ff && matched_ff && (record_in[15:0] != 16'd0);
            end else begin
               rec_pos_in = rec_pos_ff + 3'd1;
            end
         end
      end

      pos_in = (pos_ff == POS_SAT) ? pos_ff : pos_ff + 16'd1;

      // A zero interval means the tracker left it to us.
      iv_raw = (interval_in == 32'd0) ? INTERVAL_DEFAULT : interval_in;
      priority if (iv_raw < INTERVAL_MIN) begin
         iv_norm = INTERVAL_MIN[16:0];
      end else if (iv_raw > INTERVAL_MAX) begin
         iv_norm = INTERVAL_MAX[16:0];
      end else begin
         iv_norm = iv_raw[16:0];
      end

      status_w = STATUS_IGNORED;
      if (matched_in && (pos_in >= TXN_BYTES)) begin
         if (error_in) begin
            status_w = STATUS_ERROR;
         end else if (announce_in && (pos_in >= HEADER_BYTES)) begin
            status_w = STATUS_OK;
         end
      end

      result            = '0;
      result.has_peer   = peer_found;
      result.final_res  = in_last_ff;
      if (peer_found) begin
         result.peer_ip   = record_in[47:16];
         result.peer_port = record_in[15:0];
      end
      if (in_last_ff) begin
         result.status = status_w;
         if (status_w == STATUS_OK) begin
            result.interval_s = iv_norm;
            result.leechers   = leech_in;
            result.seeders    = seed_in;
         end
      end

      // The datagram ends here: the next byte starts from a clean header.
      if (in_last_ff) begin
         pos_in      = '0;
         word_in     = '0;
         announce_in = 1'b0;
         error_in    = 1'b0;
         matched_in  = 1'b0;
         interval_in = '0;
         leech_in    = '0;
         seed_in     = '0;
         record_in   = '0;
         rec_pos_in  = '0;
      end
   end

   assign result_present = peer_found || in_last_ff;
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && (!result_present || out_free);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         txn_ff       <= '0;
         pos_ff       <= '0;
         word_ff      <= '0;
         announce_ff  <= 1'b0;
         error_ff     <= 1'b0;
         matched_ff   <= 1'b0;
         interval_ff  <= '0;
         leech_ff     <= '0;
         seed_ff      <= '0;
         record_ff    <= '0;
         rec_pos_ff   <= '0;
      end else begin
         in_valid_ff <= req_take || (in_valid_ff && !advance);
         if (csr_chan.valid) begin
            txn_ff <= csr_chan.payload;
         end
         if (advance) begin
            pos_ff      <= pos_in;
            word_ff     <= word_in;
            announce_ff <= announce_in;
            error_ff    <= error_in;
            matched_ff  <= matched_in;
            interval_ff <= interval_in;
            leech_ff    <= leech_in;
            seed_ff     <= seed_in;
            record_ff   <= record_in;
            rec_pos_ff  <= rec_pos_in;
         end
         if (advance && result_present) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.payload.data_byte;
         in_last_ff <= req_chan.payload.last_byte;
      end
      if (advance && result_present) begin
         out_ff <= result;
      end
   end

   `ARP_ASSERT_IMPLY(a_peer_port_nonzero, clock, reset,
      rsp_chan.valid && rsp_chan.payload.has_peer, rsp_chan.payload.peer_port != 16'd0)
   `ARP_ASSERT_IMPLY(a_result_not_empty, clock, reset,
      rsp_chan.valid, rsp_chan.payload.has_peer || rsp_chan.payload.final_res)
   `ARP_ASSERT_IMPLY(a_interval_in_range, clock, reset,
      rsp_chan.valid && rsp_chan.payload.final_res && (rsp_chan.payload.status == STATUS_OK),
      (rsp_chan.payload.interval_s >= 17'd300) && (rsp_chan.payload.interval_s <= 17'd86400))
   `ARP_ASSERT_NEXT(a_clear_after_last, clock, reset,
      advance && in_last_ff, (pos_ff == 16'd0) && (rec_pos_ff == 3'd0) && !matched_ff)

endmodule

`default_nettype wire
